[hw/rtl/wsso_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the wheel speed and steer observation core.
// Depends on nothing; used by wsso_rpm and wheel_speed_steer_observation_core.
package wsso_pkg;

    // Configuration register map, one 32-bit word per register.
    typedef enum logic [1:0] {
        REG_WHEEL_BASE   = 2'd0,
        REG_FRONT_FRAC   = 2'd1,
        REG_GEAR_RATIO   = 2'd2,
        REG_WHEEL_RADIUS = 2'd3
    } t_reg_idx;

    localparam logic [19:0] WHEEL_BASE_RST   = 20'd101581;
    localparam logic [16:0] FRONT_FRAC_RST   = 17'd32768;
    localparam logic [23:0] GEAR_RATIO_RST   = 24'd262144;
    localparam logic [19:0] WHEEL_RADIUS_RST = 20'd16384;
    localparam logic [16:0] FRAC_ONE         = 17'd65536;

    // 30/pi with 24 fractional bits.
    localparam logic [27:0] K_30_PI = 28'd160210611;

    localparam logic [23:0]        RPM_MAX      = 24'hFFFFFF;
    localparam logic signed [18:0] STEER_MAX    = 19'sd102944;
    localparam int                 CORDIC_STEPS = 17;
    localparam int                 NORM_LOG     = 38;

    // Sum of squares is held in 58 bits, giving 29 root bits.
    localparam int SQ_W       = 58;
    localparam int SQRT_STEPS = 29;

    typedef logic signed [41:0] t_cw;

    function automatic logic [41:0] cw_mag(input t_cw v);
        cw_mag = v[41] ? 42'(-v) : 42'(v);
    endfunction

    // Divide by 2^32 with halves rounded away from zero.
    function automatic logic signed [30:0] round_shift32(input logic signed [61:0] v);
        logic [61:0] m;
        logic [61:0] s;
        m = v[61] ? 62'(-v) : 62'(v);
        s = (m + 62'h8000_0000) >> 32;
        round_shift32 = v[61] ? -$signed(31'(s)) : $signed(31'(s));
    endfunction

    // Arctangent of 2^-i in radians, Q.16.
    function automatic logic [16:0] atan_val(input int i);
        case (i)
            0:       atan_val = 17'd51472;
            1:       atan_val = 17'd30386;
            2:       atan_val = 17'd16055;
            3:       atan_val = 17'd8150;
            4:       atan_val = 17'd4091;
            5:       atan_val = 17'd2047;
            6:       atan_val = 17'd1024;
            7:       atan_val = 17'd512;
            8:       atan_val = 17'd256;
            9:       atan_val = 17'd128;
            10:      atan_val = 17'd64;
            11:      atan_val = 17'd32;
            12:      atan_val = 17'd16;
            13:      atan_val = 17'd8;
            14:      atan_val = 17'd4;
            15:      atan_val = 17'd2;
            16:      atan_val = 17'd1;
            default: atan_val = 17'd0;
        endcase
    endfunction

endpackage

[hw/rtl/wsso_rpm.sv]
`timescale 1ns / 1ps
// Pipelined wheel rpm: square root of a sum of squares, scaled by 30/pi and divided by radius.
// Depends on wsso_pkg.
module wsso_rpm #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic [23:0]                                 i_ux,
    input  logic [27:0]                                 i_us,
    input  logic [19:0]                                 i_radius,
    output logic [wsso_pkg::SQ_W-FRAC_BITS-5:0]         o_q
);
    localparam int SW = wsso_pkg::SQ_W;
    localparam int RS = wsso_pkg::SQRT_STEPS;
    localparam int QW = SW - FRAC_BITS - 4;

    logic [47:0]   r_sqx;
    logic [55:0]   r_sqs;
    logic [31:0]   r_rem  [0:RS];
    logic [RS-1:0] r_root [0:RS];
    logic [SW-1:0] r_rad  [0:RS-1];
    logic [56:0]   r_vk;
    logic [19:0]   r_drem [0:QW];
    logic [QW-1:0] r_dq   [0:QW];
    logic [QW-1:0] r_dd   [0:QW-1];
    logic [SW-1:0] n_num;

    always_ff @(posedge i_clk) begin
        r_sqx     <= 48'(i_ux) * 48'(i_ux);
        r_sqs     <= 56'(i_us) * 56'(i_us);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_rad[0]  <= SW'(r_sqx) + SW'(r_sqs);
    end

    // One root bit per stage, restoring form.
    for (genvar k = 1; k <= RS; k++) begin : g_sqrt
        logic [31:0] rem2;
        logic [31:0] trial;
        always_comb begin
            rem2  = {r_rem[k-1][29:0], r_rad[k-1][SW-1 -: 2]};
            trial = {1'b0, r_root[k-1], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (rem2 >= trial) begin
                r_rem[k]  <= rem2 - trial;
                r_root[k] <= {r_root[k-1][RS-2:0], 1'b1};
            end else begin
                r_rem[k]  <= rem2;
                r_root[k] <= {r_root[k-1][RS-2:0], 1'b0};
            end
        end
        if (k < RS) begin : g_shift
            always_ff @(posedge i_clk) begin
                r_rad[k] <= {r_rad[k-1][SW-3:0], 2'b00};
            end
        end
    end

    assign n_num = SW'(r_vk) + (SW'(i_radius) << (FRAC_BITS + 3));

    always_ff @(posedge i_clk) begin
        r_vk      <= 57'(r_root[RS]) * 57'(wsso_pkg::K_30_PI);
        r_drem[0] <= '0;
        r_dq[0]   <= '0;
        r_dd[0]   <= n_num[SW-1:FRAC_BITS+4];
    end

    // One quotient bit per stage.
    for (genvar j = 1; j <= QW; j++) begin : g_div
        logic [20:0] t;
        assign t = {r_drem[j-1], r_dd[j-1][QW-1]};
        always_ff @(posedge i_clk) begin
            if (t >= {1'b0, i_radius}) begin
                r_drem[j] <= 20'(t - {1'b0, i_radius});
                r_dq[j]   <= {r_dq[j-1][QW-2:0], 1'b1};
            end else begin
                r_drem[j] <= t[19:0];
                r_dq[j]   <= {r_dq[j-1][QW-2:0], 1'b0};
            end
        end
        if (j < QW) begin : g_shift
            always_ff @(posedge i_clk) begin
                r_dd[j] <= {r_dd[j-1][QW-2:0], 1'b0};
            end
        end
    end

    assign o_q = r_dq[QW];

endmodule

[hw/rtl/wheel_speed_steer_observation_core.sv]
`timescale 1ns / 1ps
// Top level of the kinematic bicycle observation core: register file, contact speeds, steer CORDIC.
// Depends on wsso_pkg and wsso_rpm.
//
//  Channel   Direction  Handshake                   Word
//  config    in/out     psel/penable/pwrite, APB    one 32-bit register per access
//  state     in         start (busy is never high)  vx, vy, yaw rate
//  result    out        o_strobe, one cycle         front, rear, motor rpm, steer, flag
//
// The datapath is a fixed pipeline that takes a new word in every cycle. The delay from
// acceptance to the strobe is set mainly by the 29-stage square root and the bit-per-stage
// divider.
// Reset is synchronous and clears the registers and the valid bits only; data stages are not reset.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module wheel_speed_steer_observation_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] i_long_velocity,
    input  logic signed [23:0] i_lat_velocity,
    input  logic signed [23:0] i_yaw_rate,
    output logic               o_strobe,
    output logic [23:0]        o_front_wheel_rpm,
    output logic [23:0]        o_rear_wheel_rpm,
    output logic signed [17:0] o_steer_angle,
    output logic [23:0]        o_motor_rpm,
    output logic               o_rpm_saturated
);
    localparam int QW      = wsso_pkg::SQ_W - FRAC_BITS - 4;
    localparam int RPM_LAT = 4 + wsso_pkg::SQRT_STEPS + QW;
    localparam int VT      = 4 + RPM_LAT + 2;
    localparam int SD      = RPM_LAT - 23;
    localparam int VXMIN   = ((1 << FRAC_BITS) + 50) / 100;
    localparam int CS      = wsso_pkg::CORDIC_STEPS;

    // ------------------------------------------------------------------
    // Configuration registers. The user must change them only while the core is idle; the block
    // does not enforce it, so the derived axle distances can be computed in the next cycle without harm.
    // ------------------------------------------------------------------
    logic [19:0] r_wheel_base;
    logic [16:0] r_front_frac;
    logic [23:0] r_gear_ratio;
    logic [19:0] r_wheel_radius;
    logic [16:0] n_frac_clamp;
    logic [36:0] r_lr;
    logic [36:0] r_lf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_base   <= wsso_pkg::WHEEL_BASE_RST;
            r_front_frac   <= wsso_pkg::FRONT_FRAC_RST;
            r_gear_ratio   <= wsso_pkg::GEAR_RATIO_RST;
            r_wheel_radius <= wsso_pkg::WHEEL_RADIUS_RST;
        end else if (psel && penable && pwrite) begin
            case (wsso_pkg::t_reg_idx'(paddr[3:2]))
                wsso_pkg::REG_WHEEL_BASE:   r_wheel_base   <= pwdata[19:0];
                wsso_pkg::REG_FRONT_FRAC:   r_front_frac   <= pwdata[16:0];
                wsso_pkg::REG_GEAR_RATIO:   r_gear_ratio   <= pwdata[23:0];
                wsso_pkg::REG_WHEEL_RADIUS: r_wheel_radius <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wsso_pkg::t_reg_idx'(paddr[3:2]))
            wsso_pkg::REG_WHEEL_BASE:   prdata = 32'(r_wheel_base);
            wsso_pkg::REG_FRONT_FRAC:   prdata = 32'(r_front_frac);
            wsso_pkg::REG_GEAR_RATIO:   prdata = 32'(r_gear_ratio);
            wsso_pkg::REG_WHEEL_RADIUS: prdata = 32'(r_wheel_radius);
            default:                    prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // A weight fraction above one is treated as exactly one.
    assign n_frac_clamp = (r_front_frac > wsso_pkg::FRAC_ONE) ? wsso_pkg::FRAC_ONE
                                                              : r_front_frac;

    // Rear distance is base times fraction, front distance the remainder, both Q.32.
    always_ff @(posedge i_clk) begin
        r_lr <= 37'(r_wheel_base) * 37'(n_frac_clamp);
        r_lf <= 37'(r_wheel_base) * 37'(wsso_pkg::FRAC_ONE - n_frac_clamp);
    end

    // ------------------------------------------------------------------
    // Valid bits. Every word produces exactly one result, at the end of the r_vld shift line.
    // ------------------------------------------------------------------
    logic [VT:1] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[VT-1:1], start && !busy};
        end
    end

    assign o_strobe = r_vld[VT];

    // ------------------------------------------------------------------
    // Stages 1 to 4: yaw rate times axle distances, contact lateral speeds.
    // The 37-bit distances are split so each multiplier stays narrow.
    // ------------------------------------------------------------------
    logic signed [23:0] r1_vx, r1_vy, r2_vx, r2_vy;
    logic signed [42:0] r1_plo_r, r1_plo_f;
    logic signed [43:0] r1_phi_r, r1_phi_f;
    logic signed [61:0] r2_prod_r, r2_prod_f;
    logic signed [23:0] r3_vx;
    logic signed [28:0] r3_a, r3_b;
    logic [23:0]        r4_ux;
    logic [27:0]        r4_ua, r4_ub;
    logic signed [28:0] r4_b;
    logic               r4_neg;
    logic signed [30:0] n_rnd_r, n_rnd_f;
    logic signed [31:0] n_a, n_b;

    always_ff @(posedge i_clk) begin
        r1_vx    <= i_long_velocity;
        r1_vy    <= i_lat_velocity;
        r1_plo_r <= i_yaw_rate * $signed({1'b0, r_lr[17:0]});
        r1_phi_r <= i_yaw_rate * $signed({1'b0, r_lr[36:18]});
        r1_plo_f <= i_yaw_rate * $signed({1'b0, r_lf[17:0]});
        r1_phi_f <= i_yaw_rate * $signed({1'b0, r_lf[36:18]});

        r2_vx     <= r1_vx;
        r2_vy     <= r1_vy;
        r2_prod_r <= (62'(r1_phi_r) <<< 18) + 62'(r1_plo_r);
        r2_prod_f <= (62'(r1_phi_f) <<< 18) + 62'(r1_plo_f);
    end

    always_comb begin
        n_rnd_r = wsso_pkg::round_shift32(r2_prod_r);
        n_rnd_f = wsso_pkg::round_shift32(r2_prod_f);
        n_a     = 32'(r2_vy) - 32'(n_rnd_r);
        n_b     = 32'(r2_vy) + 32'(n_rnd_f);
    end

    always_ff @(posedge i_clk) begin
        r3_vx <= r2_vx;
        r3_a  <= 29'(n_a);
        r3_b  <= 29'(n_b);

        r4_ux  <= r3_vx[23] ? 24'(-r3_vx) : 24'(r3_vx);
        r4_ua  <= r3_a[28] ? 28'(-r3_a) : 28'(r3_a);
        r4_ub  <= r3_b[28] ? 28'(-r3_b) : 28'(r3_b);
        r4_b   <= r3_b;
        r4_neg <= r3_vx[23];
    end

    // ------------------------------------------------------------------
    // Wheel rpm for each axle: root of vx^2 + s^2, times 30/pi, over radius.
    // ------------------------------------------------------------------
    logic [QW-1:0] w_qf, w_qr;

    wsso_rpm #(.FRAC_BITS(FRAC_BITS)) u_rpm_front (
        .i_clk    (i_clk),
        .i_ux     (r4_ux),
        .i_us     (r4_ub),
        .i_radius (r_wheel_radius),
        .o_q      (w_qf)
    );

    wsso_rpm #(.FRAC_BITS(FRAC_BITS)) u_rpm_rear (
        .i_clk    (i_clk),
        .i_ux     (r4_ux),
        .i_us     (r4_ua),
        .i_radius (r_wheel_radius),
        .o_q      (w_qr)
    );

    // ------------------------------------------------------------------
    // Steering angle. Both components are doubled until one magnitude
    // reaches 2^38: a binary shift search finds the largest shift that
    // keeps both below the limit, then one more doubling follows. A
    // 17-stage CORDIC in vectoring mode then yields atan(b / |vx|).
    // ------------------------------------------------------------------
    wsso_pkg::t_cw      r_sx  [0:24];
    wsso_pkg::t_cw      r_sy  [0:24];
    logic signed [18:0] r_sz  [7:24];
    logic               r_szr [0:24];
    logic               r_sng [0:24];

    always_ff @(posedge i_clk) begin
        r_sx[0]  <= 42'(r4_ux);
        r_sy[0]  <= 42'(r4_b);
        r_szr[0] <= (r4_ux <= 24'(VXMIN));
        r_sng[0] <= r4_neg;
    end

    for (genvar n = 1; n <= 6; n++) begin : g_norm
        localparam int SH = 1 << (6 - n);
        logic fits;
        assign fits = (wsso_pkg::cw_mag(r_sx[n-1]) < (42'(1) << (wsso_pkg::NORM_LOG - SH)))
                   && (wsso_pkg::cw_mag(r_sy[n-1]) < (42'(1) << (wsso_pkg::NORM_LOG - SH)));
        always_ff @(posedge i_clk) begin
            r_sx[n]  <= fits ? (r_sx[n-1] <<< SH) : r_sx[n-1];
            r_sy[n]  <= fits ? (r_sy[n-1] <<< SH) : r_sy[n-1];
            r_szr[n] <= r_szr[n-1];
            r_sng[n] <= r_sng[n-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx[7]  <= r_sx[6] <<< 1;
        r_sy[7]  <= r_sy[6] <<< 1;
        r_sz[7]  <= '0;
        r_szr[7] <= r_szr[6];
        r_sng[7] <= r_sng[6];
    end

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        localparam logic signed [18:0] ANG = $signed(19'(wsso_pkg::atan_val(i)));
        always_ff @(posedge i_clk) begin
            if (r_sy[7+i] > 0) begin
                r_sx[8+i] <= r_sx[7+i] + (r_sy[7+i] >>> i);
                r_sy[8+i] <= r_sy[7+i] - (r_sx[7+i] >>> i);
                r_sz[8+i] <= r_sz[7+i] + ANG;
            end else begin
                r_sx[8+i] <= r_sx[7+i] - (r_sy[7+i] >>> i);
                r_sy[8+i] <= r_sy[7+i] + (r_sx[7+i] >>> i);
                r_sz[8+i] <= r_sz[7+i] - ANG;
            end
            r_szr[8+i] <= r_szr[7+i];
            r_sng[8+i] <= r_sng[7+i];
        end
    end

    // Mirror for reverse travel, clamp to the steering limit, and force zero
    // when the car is all but stationary.
    logic signed [18:0] n_zs;
    logic signed [18:0] n_zc;
    logic [17:0]        n_steer;

    always_comb begin
        n_zs = r_sng[24] ? -r_sz[24] : r_sz[24];
        if (n_zs > wsso_pkg::STEER_MAX) begin
            n_zc = wsso_pkg::STEER_MAX;
        end else if (n_zs < -wsso_pkg::STEER_MAX) begin
            n_zc = -wsso_pkg::STEER_MAX;
        end else begin
            n_zc = n_zs;
        end
        n_steer = r_szr[24] ? 18'd0 : n_zc[17:0];
    end

    // The steer path is shorter than the rpm path; a shift line realigns it.
    logic [17:0] r_sdl [0:SD-1];

    always_ff @(posedge i_clk) begin
        r_sdl[0] <= n_steer;
    end

    for (genvar d = 1; d < SD; d++) begin : g_sdl
        always_ff @(posedge i_clk) begin
            r_sdl[d] <= r_sdl[d-1];
        end
    end

    assign o_steer_angle = $signed(r_sdl[SD-1]);

    // ------------------------------------------------------------------
    // Motor rpm from the unclipped rear value, then saturation of all three.
    // The rear value is split so each product stays narrow.
    // ------------------------------------------------------------------
    logic [QW-1:0]  r5_qf, r5_qr;
    logic [42:0]    r5_mlo;
    logic [QW+4:0]  r5_mhi;
    logic [QW+23:0] n_msum;
    logic [QW+7:0]  n_qm;
    logic           n_rad0, n_sat_f, n_sat_r, n_sat_m;

    always_ff @(posedge i_clk) begin
        r5_qf  <= w_qf;
        r5_qr  <= w_qr;
        r5_mlo <= 43'(w_qr[18:0]) * 43'(r_gear_ratio);
        r5_mhi <= (QW+5)'(w_qr[QW-1:19]) * (QW+5)'(r_gear_ratio);
    end

    always_comb begin
        n_msum  = ((QW+24)'(r5_mhi) << 19) + (QW+24)'(r5_mlo) + (QW+24)'(32768);
        n_qm    = n_msum[QW+23:16];
        n_rad0  = (r_wheel_radius == 20'd0);
        n_sat_f = n_rad0 || (|r5_qf[QW-1:24]);
        n_sat_r = n_rad0 || (|r5_qr[QW-1:24]);
        // With no radius the rear speed is unbounded; only a zero gear keeps the motor at rest.
        n_sat_m = n_rad0 ? (r_gear_ratio != 24'd0) : (|n_qm[QW+7:24]);
    end

    always_ff @(posedge i_clk) begin
        o_front_wheel_rpm <= n_sat_f ? wsso_pkg::RPM_MAX : r5_qf[23:0];
        o_rear_wheel_rpm  <= n_sat_r ? wsso_pkg::RPM_MAX : r5_qr[23:0];
        o_motor_rpm       <= n_sat_m ? wsso_pkg::RPM_MAX
                           : (n_rad0 ? 24'd0 : n_qm[23:0]);
        o_rpm_saturated   <= n_sat_f || n_sat_r || n_sat_m;
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for wheel_speed_steer_observation_core: random and directed vehicle states.
// Depends on wsso_pkg and the core; a bit-exact predictor in this file checks every result word.
module tb;

    localparam int LATENCY_WAIT = 100;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] yaw;
    } t_state;

    typedef struct {
        logic [23:0]        front;
        logic [23:0]        rear;
        logic signed [17:0] steer;
        logic [23:0]        motor;
        logic               sat;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic signed [23:0] i_long_velocity = '0, i_lat_velocity = '0, i_yaw_rate = '0;
    logic o_strobe;
    logic [23:0] o_front_wheel_rpm, o_rear_wheel_rpm, o_motor_rpm;
    logic signed [17:0] o_steer_angle;
    logic o_rpm_saturated;

    // Configuration as the predictor sees it.
    logic [19:0] axle_base = wsso_pkg::WHEEL_BASE_RST;
    logic [16:0] front_frac = wsso_pkg::FRONT_FRAC_RST;
    logic [23:0] gear = wsso_pkg::GEAR_RATIO_RST;
    logic [19:0] radius = wsso_pkg::WHEEL_RADIUS_RST;

    t_state   pending_states[$];
    t_reading expected_readings[$];
    int  failures = 0, results_seen = 0, gap_left = 0, cycle_count = 0;
    bit  idling_on = 1'b1;

    wheel_speed_steer_observation_core uut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint round_div32(longint v);
        longint unsigned m;
        m = (longint'(abs64(v)) + (64'd1 << 31)) >> 32;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    // Unclipped wheel rpm in Q.4, all ones when the radius is zero.
    function automatic longint unsigned wheel_rpm(longint vx, longint s);
        longint unsigned ux, us, v, den;
        ux = abs64(vx);
        us = abs64(s);
        v = int_sqrt(ux * ux + us * us);
        if (radius == 0) return '1;
        den = longint'(radius) << 20;
        return (v * 64'd160210611 + den / 2) / den;
    endfunction

    function automatic longint steer_atan(longint vx, longint b);
        longint x, y, z, xn;
        x = abs64(vx);
        y = b;
        z = 0;
        if (x <= ((64'd1 << 16) + 50) / 100) return 0;
        while (x < (64'sd1 <<< wsso_pkg::NORM_LOG)
               && abs64(y) < (64'sd1 <<< wsso_pkg::NORM_LOG)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < wsso_pkg::CORDIC_STEPS; i++) begin
            if (y > 0) begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += wsso_pkg::atan_val(i);
            end else begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= wsso_pkg::atan_val(i);
            end
            x = xn;
        end
        if (vx < 0) z = -z;
        if (z > 102944) z = 102944;
        if (z < -102944) z = -102944;
        return z;
    endfunction

    function automatic t_reading observe(t_state st);
        t_reading rd;
        longint f, lr32, lf32, a, b;
        longint unsigned qf, qr, qm;
        f = front_frac > 65536 ? 65536 : front_frac;
        lr32 = longint'(axle_base) * f;
        lf32 = longint'(axle_base) * (65536 - f);
        a = longint'(st.vy) - round_div32(longint'(st.yaw) * lr32);
        b = longint'(st.vy) + round_div32(longint'(st.yaw) * lf32);
        qf = wheel_rpm(st.vx, b);
        qr = wheel_rpm(st.vx, a);
        if (gear == 0) qm = 0;
        else if (qr > (64'd1 << 40)) qm = 64'd16777216;
        else qm = (qr * gear + 32768) >> 16;
        rd.sat = 1'b0;
        if (qf > 16777215) begin qf = 16777215; rd.sat = 1'b1; end
        if (qr > 16777215) begin qr = 16777215; rd.sat = 1'b1; end
        if (qm > 16777215) begin qm = 16777215; rd.sat = 1'b1; end
        rd.front = qf[23:0];
        rd.rear = qr[23:0];
        rd.motor = qm[23:0];
        rd.steer = 18'(steer_atan(st.vx, b));
        return rd;
    endfunction

    // Driver: presents queued states, predicts a result for each acceptance and inserts idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_readings.push_back(observe('{i_long_velocity, i_lat_velocity,
                                                      i_yaw_rate}));
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_states.size() != 0 && idling_on && $urandom_range(0, 9) == 0)
            begin
                gap_left <= $urandom_range(0, 10);
                start <= 1'b0;
            end else if (pending_states.size() != 0) begin
                t_state st;
                st = pending_states.pop_front();
                i_long_velocity <= st.vx;
                i_lat_velocity <= st.vy;
                i_yaw_rate <= st.yaw;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed word is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            t_reading ex;
            results_seen <= results_seen + 1;
            if (expected_readings.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                failures <= failures + 1;
            end else begin
                ex = expected_readings.pop_front();
                if (ex.front !== o_front_wheel_rpm || ex.rear !== o_rear_wheel_rpm
                    || ex.steer !== o_steer_angle || ex.motor !== o_motor_rpm
                    || ex.sat !== o_rpm_saturated) begin
                    $display("%0t: expected front %0d rear %0d steer %0d motor %0d sat %0b",
                             $time, ex.front, ex.rear, ex.steer, ex.motor, ex.sat);
                    $display("%0t: actual   front %0d rear %0d steer %0d motor %0d sat %0b",
                             $time, o_front_wheel_rpm, o_rear_wheel_rpm, o_steer_angle,
                             o_motor_rpm, o_rpm_saturated);
                    failures <= failures + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic reg_write(wsso_pkg::t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(logic [19:0] wb, logic [16:0] ff, logic [23:0] gr,
                              logic [19:0] rad);
        reg_write(wsso_pkg::REG_WHEEL_BASE, wb);
        reg_write(wsso_pkg::REG_FRONT_FRAC, ff);
        reg_write(wsso_pkg::REG_GEAR_RATIO, gr);
        reg_write(wsso_pkg::REG_WHEEL_RADIUS, rad);
        axle_base = wb;
        front_frac = ff;
        gear = gr;
        radius = rad;
    endtask

    function automatic logic signed [23:0] rand_signed(int lim);
        return 24'($signed($urandom_range(0, 2 * lim)) - lim);
    endfunction

    // Mostly plausible driving states, with some full-range words for bit coverage.
    function automatic t_state random_state();
        t_state st;
        case ($urandom_range(0, 9))
            0, 1: st = '{24'($urandom), 24'($urandom), 24'($urandom)};
            2:    st = '{rand_signed(1200), rand_signed(3000), rand_signed(20000)};
            default: st = '{rand_signed(40 << 16), rand_signed(4 << 16), rand_signed(2 << 16)};
        endcase
        return st;
    endfunction

    task automatic drain();
        wait (pending_states.size() == 0 && !start && expected_readings.size() == 0);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    initial begin
        logic signed [23:0] edge_vals[8];
        edge_vals = '{24'sh7FFFFF, -24'sh800000, 24'sd0, 24'sd655, -24'sd655, 24'sd656,
                      -24'sd656, 24'sd65536};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes and the low-speed steering boundary, at reset configuration.
        for (int i = 0; i < 8; i++)
            pending_states.push_back('{edge_vals[i], edge_vals[(i + 3) % 8],
                                       edge_vals[(i + 5) % 8]});
        pending_states.push_back('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF});
        pending_states.push_back('{-24'sh800000, -24'sh800000, -24'sh800000});
        pending_states.push_back('{24'sd0, 24'sd0, 24'sd0});
        pending_states.push_back('{-24'sd700, 24'sd65536, 24'sd0});
        for (int i = 0; i < 120; i++) pending_states.push_back(random_state());
        drain();

        // Zero gear ratio, front weight fraction of nought, shortest axle and radius.
        set_config(20'd1, 17'd0, 24'd0, 20'd1);
        for (int i = 0; i < 120; i++) pending_states.push_back(random_state());
        drain();

        // Largest axle, radius and gear ratio, all weight on the front.
        set_config(20'hFFFFF, 17'd65536, 24'hFFFFFF, 20'hFFFFF);
        for (int i = 0; i < 120; i++) pending_states.push_back(random_state());
        drain();

        // A small radius with a high gear ratio drives the rpm outputs into saturation.
        set_config(20'd98304, 17'd26000, 24'd900000, 20'd300);
        for (int i = 0; i < 120; i++) pending_states.push_back(random_state());
        drain();

        // Back-to-back words with no idling at a typical setting.
        set_config(20'd101581, 17'd39321, 24'd262144, 20'd16384);
        idling_on = 1'b0;
        for (int i = 0; i < 160; i++) pending_states.push_back(random_state());
        drain();

        $display("Checked %0d result words over five register settings,", results_seen);
        $display("covering field extremes, low-speed steering and rpm saturation.");
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
